>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

>>> sv/fga_pkg.sv
// ---------------------------------------------------------------------------
// fga_pkg
// Shared widths, opcodes and types of the group aggregation block.
// ---------------------------------------------------------------------------
package fga_pkg;

  localparam int MAX_BUCKETS = 8;
  localparam int ADDR_W      = $clog2(MAX_BUCKETS);
  localparam int OP_W        = 2;
  localparam int BUCKET_W    = 3;
  localparam int DATA_W      = 32;
  localparam int ACTIVE_W    = 4;
  localparam int CFG_IDX_W   = 1;

  localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RD    = 2'd1;
  localparam logic [OP_W-1:0] OP_RDCLR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PASS_DATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 1'd1;

  localparam logic [DATA_W-1:0]   PASS_DATE_RESET = 32'd100;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET    = 4'd6;

  // One bucket's six accumulators.
  typedef struct packed {
    logic [DATA_W-1:0] qty;
    logic [DATA_W-1:0] price;
    logic [DATA_W-1:0] disc_price;
    logic [DATA_W-1:0] charge;
    logic [DATA_W-1:0] discount;
    logic [DATA_W-1:0] count;
  } acc_t;

  // Access to the bucket table: read or write, never both in one cycle.
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    acc_t              wdata;
  } store_req_t;

endpackage

>>> sv/fga_ifs.sv
// ---------------------------------------------------------------------------
// fga_ifs
// Valid/ready channels: row input, bucket totals output, register writes.
// ---------------------------------------------------------------------------
interface fga_row_if
  import fga_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic        [OP_W-1:0]     opcode;
  logic        [BUCKET_W-1:0] bucket;
  logic signed [DATA_W-1:0]   ship_date;
  logic signed [DATA_W-1:0]   quantity;
  logic signed [DATA_W-1:0]   ext_price;
  logic signed [DATA_W-1:0]   discount;
  logic signed [DATA_W-1:0]   tax;

  modport source (output valid, opcode, bucket, ship_date, quantity, ext_price,
                  discount, tax, input ready);
  modport sink   (input valid, opcode, bucket, ship_date, quantity, ext_price,
                  discount, tax, output ready);
endinterface

interface fga_total_if
  import fga_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic        [BUCKET_W-1:0] read_bucket;
  logic signed [DATA_W-1:0]   total_qty;
  logic signed [DATA_W-1:0]   total_price;
  logic signed [DATA_W-1:0]   total_disc_price;
  logic signed [DATA_W-1:0]   total_charge;
  logic signed [DATA_W-1:0]   total_discount;
  logic signed [DATA_W-1:0]   row_count;

  modport source (output valid, read_bucket, total_qty, total_price, total_disc_price,
                  total_charge, total_discount, row_count, input ready);
  modport sink   (input valid, read_bucket, total_qty, total_price, total_disc_price,
                  total_charge, total_discount, row_count, output ready);
endinterface

interface fga_cfg_if
  import fga_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/fga_store.sv
// ---------------------------------------------------------------------------
// fga_store
// Bucket table: one synchronous memory of accumulator rows, registered read,
// per-row valid flags so that rows never written since reset read as zero.
// ---------------------------------------------------------------------------
module fga_store
  import fga_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  output acc_t       rdata
);

  acc_t                   mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] vld_r;
  acc_t                   rd_q_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.addr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_q_r : '0;

`include "assert_macros.svh"

  `ASSERT_CLK(a_no_rd_wr_same_cycle, !(req.rd_en && req.wr_en), "store read and write collide")
  `ASSERT_NEXT(a_written_row_valid, req.wr_en, vld_r[$past(req.addr)], "written row not marked valid")
  `ASSERT_NEXT(a_unwritten_reads_zero, req.rd_en && !vld_r[req.addr], rdata == '0, "fresh row not zero")

endmodule

>>> sv/filtered_group_aggregate.sv
// ---------------------------------------------------------------------------
// filtered_group_aggregate
// Group-by aggregation of row words into an eight-bucket accumulator table.
// ---------------------------------------------------------------------------
// The table row of an input word is read when the word is accepted, the
// (price+discount)*(1+tax) product is formed in the next cycle, and the row
// is written back in the write-back state; no new word is accepted before
// then, so a row may hit its predecessor's bucket without hazard. A read
// word waits in write-back while the output register holds the previous
// totals word. The table needs no clearing pass: per-row valid flags make
// it read as zero right after reset. Register writes are taken in any cycle.
module filtered_group_aggregate
  import fga_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  fga_row_if.sink   in_ch,
  fga_total_if.source out_ch,
  fga_cfg_if.sink   cfg_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [DATA_W-1:0]   pass_date_r;
  logic [ACTIVE_W-1:0] active_r;

  logic [OP_W-1:0]     op_r;
  logic [ADDR_W-1:0]   bucket_r;
  logic                hit_r;
  logic [DATA_W-1:0]   qty_r, price_r, disc_r, pd_r, tax1_r, charge_r;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_bucket_r;
  acc_t                out_acc_r;

  store_req_t req;
  acc_t       rdata;
  acc_t       upd;
  logic       in_acc, is_read, out_free, wb_done;

  fga_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rdata (rdata)
  );

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_date_r <= PASS_DATE_RESET;
      active_r    <= ACTIVE_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PASS_DATE: pass_date_r <= cfg_ch.data;
        CFG_ACTIVE:    active_r    <= cfg_ch.data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_read     = (op_r == OP_RD) || (op_r == OP_RDCLR);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign wb_done     = (state_r == ST_WB) && (!is_read || out_free);

  always_comb begin
    upd.qty        = rdata.qty + qty_r;
    upd.price      = rdata.price + price_r;
    upd.disc_price = rdata.disc_price + pd_r;
    upd.charge     = rdata.charge + charge_r;
    upd.discount   = rdata.discount + disc_r;
    upd.count      = rdata.count + DATA_W'(1);
  end

  always_comb begin
    req.rd_en = in_acc;
    req.wr_en = wb_done && (((op_r == OP_ACC) && hit_r) || (op_r == OP_RDCLR));
    req.addr  = in_acc ? ADDR_W'(in_ch.bucket) : bucket_r;
    req.wdata = (op_r == OP_RDCLR) ? '0 : upd;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WB;
      ST_WB:   if (wb_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wb_done && is_read) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Row payload; only the product stage and write-back use it.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_ch.opcode;
      bucket_r <= ADDR_W'(in_ch.bucket);
      hit_r    <= (in_ch.ship_date == pass_date_r) &&
                  ({1'b0, in_ch.bucket} < active_r);
      qty_r    <= in_ch.quantity;
      price_r  <= in_ch.ext_price;
      disc_r   <= in_ch.discount;
      pd_r     <= in_ch.ext_price + in_ch.discount;
      tax1_r   <= in_ch.tax + DATA_W'(1);
    end
    if (state_r == ST_MUL) begin
      charge_r <= pd_r * tax1_r;  // low word only
    end
    if (wb_done && is_read) begin
      out_bucket_r <= bucket_r;
      out_acc_r    <= rdata;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.read_bucket      = BUCKET_W'(out_bucket_r);
  assign out_ch.total_qty        = out_acc_r.qty;
  assign out_ch.total_price      = out_acc_r.price;
  assign out_ch.total_disc_price = out_acc_r.disc_price;
  assign out_ch.total_charge     = out_acc_r.charge;
  assign out_ch.total_discount   = out_acc_r.discount;
  assign out_ch.row_count        = out_acc_r.count;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_mul_then_wb, state_r == ST_MUL, state_r == ST_WB, "product stage skipped")
  `ASSERT_NEXT(a_read_waits, (state_r == ST_WB) && is_read && !out_free, (state_r == ST_WB) && !$past(req.wr_en), "read left while output full")
  `ASSERT_NEXT(a_acc_no_word, (state_r == ST_WB) && !is_read && !out_valid_r, !out_valid_r, "accumulate produced a word")

endmodule

>>> tb/filtered_group_aggregate_test.sv
// ---------------------------------------------------------------------------
// filtered_group_aggregate_test
// Self-checking bench for the group aggregation block. Rows, reads and
// read-and-clears are streamed through the row channel under random idling
// on both sides. A bucket table predictor computes the expected totals words,
// which are checked in order against the block's output. The pass date and
// the active bucket count are changed between phases while the block is idle.
// ---------------------------------------------------------------------------
module filtered_group_aggregate_test;
  import fga_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 10;
  localparam int IDLE_PCT        = 17;
  localparam int SETTLE_CYCLES   = 6;
  localparam int STALL_LIMIT     = 2000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 300;

  // opcode 3 has no function
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [BUCKET_W-1:0] bucket;
    logic [DATA_W-1:0]   ship_date;
    logic [DATA_W-1:0]   quantity;
    logic [DATA_W-1:0]   ext_price;
    logic [DATA_W-1:0]   discount;
    logic [DATA_W-1:0]   tax;
  } row_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] read_bucket;
    acc_t                sums;
  } total_t;

  class group_totals_board;
    logic [DATA_W-1:0]   pass_date;
    logic [ACTIVE_W-1:0] active_buckets;
    acc_t                sums [MAX_BUCKETS];
    total_t              pending_totals [$];
    int unsigned         errors;

    function new();
      pass_date      = PASS_DATE_RESET;
      active_buckets = ACTIVE_RESET;
      foreach (sums[i]) sums[i] = '0;
      errors = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        CFG_PASS_DATE: pass_date = value;
        CFG_ACTIVE:    active_buckets = value[ACTIVE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_row(row_t r);
      logic [DATA_W-1:0] pd;
      total_t            t;
      case (r.op) inside
        OP_ACC: begin
          if (r.ship_date == pass_date && r.bucket < active_buckets) begin
            pd = r.ext_price + r.discount;
            sums[r.bucket].qty        += r.quantity;
            sums[r.bucket].price      += r.ext_price;
            sums[r.bucket].disc_price += pd;
            sums[r.bucket].charge     += pd * (r.tax + 32'd1);
            sums[r.bucket].discount   += r.discount;
            sums[r.bucket].count      += 32'd1;
          end
        end
        OP_RD, OP_RDCLR: begin
          t.read_bucket = r.bucket;
          t.sums        = sums[r.bucket];
          pending_totals.push_back(t);
          if (r.op == OP_RDCLR) sums[r.bucket] = '0;
        end
        default: ;
      endcase
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    function string field_diff(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got === want) return "";
      return $sformatf(" %s exp %h got %h;", name, want, got);
    endfunction

    function void check_totals(total_t got);
      total_t want;
      string  diffs;
      if (pending_totals.size() == 0) begin
        report($sformatf("totals word for bucket %0d with none pending", got.read_bucket));
        return;
      end
      want  = pending_totals.pop_front();
      diffs = "";
      if (got.read_bucket !== want.read_bucket)
        diffs = $sformatf(" read_bucket exp %0d got %0d;", want.read_bucket, got.read_bucket);
      diffs = {diffs, field_diff("total_qty", want.sums.qty, got.sums.qty)};
      diffs = {diffs, field_diff("total_price", want.sums.price, got.sums.price)};
      diffs = {diffs, field_diff("total_disc_price", want.sums.disc_price,
                                 got.sums.disc_price)};
      diffs = {diffs, field_diff("total_charge", want.sums.charge, got.sums.charge)};
      diffs = {diffs, field_diff("total_discount", want.sums.discount, got.sums.discount)};
      diffs = {diffs, field_diff("row_count", want.sums.count, got.sums.count)};
      if (diffs != "") report({"totals mismatch:", diffs});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic calm = 1'b0;
  int unsigned quiet_cycles = 0;

  group_totals_board board = new();

  fga_row_if   row_ch ();
  fga_total_if total_ch ();
  fga_cfg_if   reg_ch ();

  filtered_group_aggregate i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (row_ch),
    .out_ch (total_ch),
    .cfg_ch (reg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) begin
    total_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Observe all three handshakes; totals are checked before the new row is
  // noted, though a read's result never leaves in its own accept cycle.
  always @(posedge clk) begin : monitor
    row_t   r;
    total_t t;
    logic   moved;
    if (rst_n) begin
      moved = 1'b0;
      if (total_ch.valid && total_ch.ready) begin
        t.read_bucket     = total_ch.read_bucket;
        t.sums.qty        = total_ch.total_qty;
        t.sums.price      = total_ch.total_price;
        t.sums.disc_price = total_ch.total_disc_price;
        t.sums.charge     = total_ch.total_charge;
        t.sums.discount   = total_ch.total_discount;
        t.sums.count      = total_ch.row_count;
        board.check_totals(t);
        moved = 1'b1;
      end
      if (row_ch.valid && row_ch.ready) begin
        r.op        = row_ch.opcode;
        r.bucket    = row_ch.bucket;
        r.ship_date = row_ch.ship_date;
        r.quantity  = row_ch.quantity;
        r.ext_price = row_ch.ext_price;
        r.discount  = row_ch.discount;
        r.tax       = row_ch.tax;
        board.note_row(r);
        moved = 1'b1;
      end
      if (reg_ch.valid && reg_ch.ready) begin
        board.write_register(reg_ch.index, reg_ch.data);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("filtered_group_aggregate_test NOT OK");
    $finish;
  end

  function automatic row_t make_row(logic [OP_W-1:0] op, logic [BUCKET_W-1:0] bucket,
                                    logic [DATA_W-1:0] ship_date, logic [DATA_W-1:0] qty,
                                    logic [DATA_W-1:0] price, logic [DATA_W-1:0] disc,
                                    logic [DATA_W-1:0] tax);
    row_t r;
    r.op        = op;
    r.bucket    = bucket;
    r.ship_date = ship_date;
    r.quantity  = qty;
    r.ext_price = price;
    r.discount  = disc;
    r.tax       = tax;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 11)) inside
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return '0;
      4, 5:    return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  // Mostly matching rows so the sums grow; reads spread over all buckets.
  function automatic row_t random_row(logic [DATA_W-1:0] pass);
    int                roll;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] date;
    roll = $urandom_range(0, 99);
    op = (roll < 68) ? OP_ACC : (roll < 82) ? OP_RD : (roll < 96) ? OP_RDCLR : OP_SPARE;
    case ($urandom_range(0, 11))
      0:       date = $urandom();
      1:       date = pass + 32'd1;
      2:       date = pass - 32'd1;
      default: date = pass;
    endcase
    return make_row(op, BUCKET_W'($urandom_range(0, MAX_BUCKETS - 1)), date, pick_word(),
                    pick_word(), pick_word(), pick_word());
  endfunction

  // All driving tasks are entered and left at a falling edge.
  task automatic send_row(input row_t r);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      row_ch.valid = 1'b0;
      @(negedge clk);
    end
    row_ch.valid     = 1'b1;
    row_ch.opcode    = r.op;
    row_ch.bucket    = r.bucket;
    row_ch.ship_date = r.ship_date;
    row_ch.quantity  = r.quantity;
    row_ch.ext_price = r.ext_price;
    row_ch.discount  = r.discount;
    row_ch.tax       = r.tax;
    @(posedge clk);
    while (!row_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    reg_ch.valid = 1'b1;
    reg_ch.index = idx;
    reg_ch.data  = value;
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
    @(negedge clk);
    reg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    row_ch.valid = 1'b0;
    while (board.pending_totals.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0]   date;
    logic [ACTIVE_W-1:0] active;
    logic [DATA_W-1:0]   active_word;
    int unsigned         fail_count;

    rst_n            = 1'b0;
    row_ch.valid     = 1'b0;
    row_ch.opcode    = OP_ACC;
    row_ch.bucket    = '0;
    row_ch.ship_date = '0;
    row_ch.quantity  = '0;
    row_ch.ext_price = '0;
    row_ch.discount  = '0;
    row_ch.tax       = '0;
    reg_ch.valid     = 1'b0;
    reg_ch.index     = CFG_PASS_DATE;
    reg_ch.data      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, reset settings: pass date 100, six active buckets
    send_row(make_row(OP_RD, 0, 0, 0, 0, 0, 0));
    send_row(make_row(OP_RD, 7, 0, 0, 0, 0, 0));
    send_row(make_row(OP_ACC, 0, 100, 32'h7fff_ffff, 32'h8000_0000, '1, 32'h7fff_ffff));
    // tax of -1 zeroes the charge term
    send_row(make_row(OP_ACC, 0, 100, 1, 32'h7fff_ffff, 1, '1));
    send_row(make_row(OP_ACC, 0, 100, 32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000));
    send_row(make_row(OP_ACC, 5, 100, '1, '1, '1, '1));
    send_row(make_row(OP_ACC, 6, 100, 5, 6, 7, 8));       // inactive bucket
    send_row(make_row(OP_ACC, 7, 100, 5, 6, 7, 8));
    send_row(make_row(OP_ACC, 1, 101, 5, 6, 7, 8));       // date mismatch
    send_row(make_row(OP_ACC, 1, 32'h8000_0000, 5, 6, 7, 8));
    send_row(make_row(OP_SPARE, 2, 100, 5, 6, 7, 8));
    send_row(make_row(OP_RD, 0, 0, 0, 0, 0, 0));
    send_row(make_row(OP_RD, 5, 0, 0, 0, 0, 0));
    send_row(make_row(OP_RDCLR, 0, 0, 0, 0, 0, 0));
    send_row(make_row(OP_RD, 0, 0, 0, 0, 0, 0));
    send_row(make_row(OP_RD, 6, 0, 0, 0, 0, 0));
    // back-to-back rows into one bucket, then read it at once
    send_row(make_row(OP_ACC, 3, 100, 1, 2, 3, 4));
    send_row(make_row(OP_ACC, 3, 100, 10, 20, 30, 40));
    send_row(make_row(OP_ACC, 3, 100, 100, 200, 300, 400));
    send_row(make_row(OP_RDCLR, 3, 0, 0, 0, 0, 0));
    send_row(make_row(OP_RDCLR, 5, 0, 0, 0, 0, 0));
    send_row(make_row(OP_RD, 1, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin date = 32'h8000_0000; active = 4'd8;  end
        1:       begin date = 32'h7fff_ffff; active = 4'd1;  end
        2:       begin date = '1;            active = 4'd15; end
        3:       begin date = '0;            active = 4'd0;  end
        4:       begin date = $urandom();    active = ACTIVE_W'($urandom_range(1, 8)); end
        default: begin date = PASS_DATE_RESET; active = ACTIVE_RESET; end
      endcase
      // rows leave no totals word, so give the pipeline time to empty
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clk);
      // upper data bits are don't-care for the bucket count
      active_word = ($urandom() & 32'hffff_fff0) | DATA_W'(active);
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_PASS_DATE, date);
        write_reg(CFG_ACTIVE, active_word);
      end else begin
        write_reg(CFG_ACTIVE, active_word);
        write_reg(CFG_PASS_DATE, date);
      end
      calm = (ph == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 199) == 0) wait_drained();
        send_row(random_row(board.pass_date));
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count = board.errors + board.pending_totals.size();
    if (fail_count == 0) begin
      $display("filtered_group_aggregate_test OK");
    end else begin
      $display("filtered_group_aggregate_test NOT OK");
    end
    $finish;
  end

endmodule
